>>> hdl/cnfp_pkg.sv
// ---------------------------------------------------------------------------
// cnfp_pkg
// Shared types and fixed widths of the centroid / nearest / farthest point unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cnfp_pkg;

	localparam int COORD_W = 16;   // coordinate width
	localparam int FRAC_W  = 8;    // centroid fraction bits
	localparam int CEN_W   = 24;   // centroid output width
	localparam int PCNT_W  = 5;    // point_count output width

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STARTX,
		ST_WAITX,
		ST_STARTY,
		ST_WAITY,
		ST_READ,
		ST_MX,
		ST_MY,
		ST_SQX,
		ST_SQY,
		ST_CMP,
		ST_OUT
	} cnfp_state_t;

endpackage

`default_nettype wire

>>> hdl/cnfp_ram.sv
// ---------------------------------------------------------------------------
// cnfp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/cnfp_div.sv
// ---------------------------------------------------------------------------
// cnfp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnfp_div #(
	parameter int DVD_W = 29,
	parameter int DVS_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

>>> hdl/centroid_nearest_farthest_point_unit.sv
// ---------------------------------------------------------------------------
// centroid_nearest_farthest_point_unit
// Collects a set of 2-D points, then reports the centroid and the stored
// points nearest to and farthest from it.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | in_valid/in_stall  | coord_x, coord_y, last_point
//  output  | out_valid/out_stall| centroid_x/y, nearest_x/y, farthest_x/y,
//          |                    | point_count, overflow
//
//  A point that does not close its set is taken without stalling the input.
//  The closing point starts two passes through the bit-serial divider,
//  x then y, then six steps per stored point through the shared multiplier.
//  in_stall is high after the closing transfer until the result is loaded
//  into the output register; a result held back by out_stall holds off all input.
//  Reset clears the control state; the point store is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module centroid_nearest_farthest_point_unit #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [cnfp_pkg::COORD_W-1:0]   coord_x,
	input  wire logic signed [cnfp_pkg::COORD_W-1:0]   coord_y,
	input  wire logic                                  last_point,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed      [cnfp_pkg::CEN_W-1:0]     centroid_x,
	output logic signed      [cnfp_pkg::CEN_W-1:0]     centroid_y,
	output logic signed      [cnfp_pkg::COORD_W-1:0]   nearest_x,
	output logic signed      [cnfp_pkg::COORD_W-1:0]   nearest_y,
	output logic signed      [cnfp_pkg::COORD_W-1:0]   farthest_x,
	output logic signed      [cnfp_pkg::COORD_W-1:0]   farthest_y,
	output logic             [cnfp_pkg::PCNT_W-1:0]    point_count,
	output logic                                       overflow
);

	localparam int COORD_W = cnfp_pkg::COORD_W;
	localparam int CEN_W   = cnfp_pkg::CEN_W;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SUM_W   = COORD_W + CNT_W;
	localparam int DIFF_W  = SUM_W + 1;
	localparam int DIST_W  = 2 * DIFF_W;
	localparam int QW      = SUM_W + cnfp_pkg::FRAC_W;
	localparam int QX_W    = (QW > CEN_W) ? QW + 1 : CEN_W + 1;

	localparam logic [QX_W-1:0] CEN_MAG = QX_W'(1) << (CEN_W - 1);
	localparam logic signed [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
	localparam logic signed [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};

	// sign and magnitude back to fixed point, saturating
	function automatic logic signed [CEN_W-1:0] to_fixed(input logic neg,
			input logic [QW-1:0] q);
		logic [QX_W-1:0]         qx;
		logic signed [CEN_W-1:0] r;
		qx = QX_W'(q);
		if (neg) begin
			r = (qx > CEN_MAG) ? CEN_MIN : -$signed(qx[CEN_W-1:0]);
		end else begin
			r = (qx > CEN_MAG - 1'b1) ? CEN_MAX : $signed(qx[CEN_W-1:0]);
		end
		return r;
	endfunction

	cnfp_pkg::cnfp_state_t state_q, state_d;

	logic [CNT_W-1:0]           count_q;
	logic signed [SUM_W-1:0]    sum_x_q, sum_y_q;
	logic                       ovf_q;
	logic [CNT_W-1:0]           idx_q;

	logic signed [CEN_W-1:0]    cx_q, cy_q;
	logic signed [DIFF_W-1:0]   dx_q, dy_q;
	logic signed [DIST_W-1:0]   prod_q;
	logic [DIST_W-1:0]          acc_q;
	logic [DIST_W-1:0]          near_d_q, far_d_q;
	logic [2*COORD_W-1:0]       near_pt_q, far_pt_q;

	logic                       in_xfer;
	logic                       out_load;
	logic                       ram_we;
	logic [2*COORD_W-1:0]       ram_rdata;
	logic                       div_start;
	logic                       div_done;
	logic [QW-1:0]              div_dvd;
	logic [QW-1:0]              div_q;
	logic signed [SUM_W-1:0]    div_sum;
	logic [SUM_W-1:0]           div_mag;
	logic signed [DIFF_W-1:0]   mul_a, mul_b;
	logic signed [DIST_W-1:0]   mul_p;
	logic signed [COORD_W-1:0]  pt_x, pt_y;
	logic [DIST_W-1:0]          dist_sq;
	logic                       last_idx;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != cnfp_pkg::ST_IDLE);
	assign ram_we   = in_xfer && (count_q < CNT_W'(MAX_POINTS));

	assign pt_x     = $signed(ram_rdata[2*COORD_W-1:COORD_W]);
	assign pt_y     = $signed(ram_rdata[COORD_W-1:0]);
	assign dist_sq  = acc_q + $unsigned(prod_q);
	assign last_idx = (idx_q == count_q - 1'b1);

	cnfp_ram #(
		.WIDTH (2 * COORD_W),
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({coord_x, coord_y}),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// divide |sum| * 2^FRAC by n, x first then y
	assign div_sum = (state_q == cnfp_pkg::ST_STARTY) ? sum_y_q : sum_x_q;
	assign div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
	assign div_dvd = {div_mag, {cnfp_pkg::FRAC_W{1'b0}}};

	cnfp_div #(
		.DVD_W (QW),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = $signed(DIFF_W'(count_q));
		mul_b = DIFF_W'(pt_x);
		case (state_q)
			cnfp_pkg::ST_MY: begin
				mul_b = DIFF_W'(pt_y);
			end
			cnfp_pkg::ST_SQX: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			cnfp_pkg::ST_SQY: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			cnfp_pkg::ST_IDLE: begin
				if (in_xfer && last_point) begin
					state_d = cnfp_pkg::ST_STARTX;
				end
			end
			cnfp_pkg::ST_STARTX: begin
				div_start = 1'b1;
				state_d   = cnfp_pkg::ST_WAITX;
			end
			cnfp_pkg::ST_WAITX: begin
				if (div_done) begin
					state_d = cnfp_pkg::ST_STARTY;
				end
			end
			cnfp_pkg::ST_STARTY: begin
				div_start = 1'b1;
				state_d   = cnfp_pkg::ST_WAITY;
			end
			cnfp_pkg::ST_WAITY: begin
				if (div_done) begin
					state_d = cnfp_pkg::ST_READ;
				end
			end
			cnfp_pkg::ST_READ: state_d = cnfp_pkg::ST_MX;
			cnfp_pkg::ST_MX:   state_d = cnfp_pkg::ST_MY;
			cnfp_pkg::ST_MY:   state_d = cnfp_pkg::ST_SQX;
			cnfp_pkg::ST_SQX:  state_d = cnfp_pkg::ST_SQY;
			cnfp_pkg::ST_SQY:  state_d = cnfp_pkg::ST_CMP;
			cnfp_pkg::ST_CMP: begin
				state_d = last_idx ? cnfp_pkg::ST_OUT : cnfp_pkg::ST_READ;
			end
			cnfp_pkg::ST_OUT: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d  = cnfp_pkg::ST_IDLE;
				end
			end
			default: state_d = cnfp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cnfp_pkg::ST_IDLE;
			count_q   <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				if (ram_we) begin
					count_q <= count_q + 1'b1;
					sum_x_q <= sum_x_q + SUM_W'(coord_x);
					sum_y_q <= sum_y_q + SUM_W'(coord_y);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == cnfp_pkg::ST_WAITY) begin
				idx_q <= '0;
			end else if (state_q == cnfp_pkg::ST_CMP && !last_idx) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
				count_q   <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				ovf_q     <= 1'b0;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == cnfp_pkg::ST_WAITX && div_done) begin
			cx_q <= to_fixed(sum_x_q[SUM_W-1], div_q);
		end
		if (state_q == cnfp_pkg::ST_WAITY && div_done) begin
			cy_q <= to_fixed(sum_y_q[SUM_W-1], div_q);
		end
		prod_q <= mul_p;
		case (state_q)
			cnfp_pkg::ST_MY:  dx_q  <= prod_q[DIFF_W-1:0] - DIFF_W'(sum_x_q);
			cnfp_pkg::ST_SQX: dy_q  <= prod_q[DIFF_W-1:0] - DIFF_W'(sum_y_q);
			cnfp_pkg::ST_SQY: acc_q <= $unsigned(prod_q);
			cnfp_pkg::ST_CMP: begin
				// strict compares keep the earliest point on ties
				if (idx_q == '0 || dist_sq < near_d_q) begin
					near_d_q  <= dist_sq;
					near_pt_q <= ram_rdata;
				end
				if (idx_q == '0 || dist_sq > far_d_q) begin
					far_d_q  <= dist_sq;
					far_pt_q <= ram_rdata;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			centroid_x  <= cx_q;
			centroid_y  <= cy_q;
			nearest_x   <= $signed(near_pt_q[2*COORD_W-1:COORD_W]);
			nearest_y   <= $signed(near_pt_q[COORD_W-1:0]);
			farthest_x  <= $signed(far_pt_q[2*COORD_W-1:COORD_W]);
			farthest_y  <= $signed(far_pt_q[COORD_W-1:0]);
			point_count <= cnfp_pkg::PCNT_W'(count_q);
			overflow    <= ovf_q;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == cnfp_pkg::ST_WAITX || state_q == cnfp_pkg::ST_WAITY))
		else $error("divider finished outside a wait state");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cnfp_pkg::ST_CMP) |-> (idx_q < count_q))
		else $error("scan index past stored points");

	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last_point) |=> in_stall)
		else $error("closing transfer did not start the computation");
`endif

endmodule

`default_nettype wire

>>> verif/centroid_nearest_farthest_point_unit_tb.sv
// ---------------------------------------------------------------------------
// centroid_nearest_farthest_point_unit_tb
// Sends sets of 2-D points to the unit and checks every result against a
// local model of the set: centroid in fixed point with truncation toward
// zero, and the nearest and farthest stored points, with the earliest point
// winning a tie. Points past the store limit are dropped and flagged.
// Directed sets come first, then random sets under varying back-pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module centroid_nearest_farthest_point_unit_tb;

	localparam int     COORD_W = cnfp_pkg::COORD_W;
	localparam int     FRAC_W  = cnfp_pkg::FRAC_W;
	localparam int     CEN_W   = cnfp_pkg::CEN_W;
	localparam int     PCNT_W  = cnfp_pkg::PCNT_W;
	localparam int     MAX_PTS = 16;
	localparam longint CEN_HI  = (longint'(1) <<< (CEN_W - 1)) - 1;
	localparam longint CEN_LO  = -CEN_HI - 1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		logic signed [CEN_W-1:0] cx;
		logic signed [CEN_W-1:0] cy;
		coord_t                  nx;
		coord_t                  ny;
		coord_t                  fx;
		coord_t                  fy;
		logic [PCNT_W-1:0]       n;
		logic                    dropped;
	} set_summary_t;

	typedef enum int {
		SPREAD_FULL,
		SPREAD_TINY,
		SPREAD_EDGES,
		SPREAD_CLUSTER
	} spread_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	coord_t                    coord_x;
	coord_t                    coord_y;
	logic                      last_point;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [CEN_W-1:0]   centroid_x;
	logic signed [CEN_W-1:0]   centroid_y;
	coord_t                    nearest_x;
	coord_t                    nearest_y;
	coord_t                    farthest_x;
	coord_t                    farthest_y;
	logic [PCNT_W-1:0]         point_count;
	logic                      overflow;

	// model of the set being collected
	coord_t       pt_x [MAX_PTS];
	coord_t       pt_y [MAX_PTS];
	int           set_n;
	longint       sum_x;
	longint       sum_y;
	logic         set_dropped;

	set_summary_t expected_summaries[$];
	int           mismatch_count;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           points_sent;

	centroid_nearest_farthest_point_unit #(.MAX_POINTS(MAX_PTS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.last_point (last_point),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.nearest_x  (nearest_x),
		.nearest_y  (nearest_y),
		.farthest_x (farthest_x),
		.farthest_y (farthest_y),
		.point_count(point_count),
		.overflow   (overflow)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// squared distance to the centroid, scaled by n^2
	function automatic longint scaled_dist(input int i);
		longint dx;
		longint dy;
		dx = longint'(set_n) * longint'(pt_x[i]) - sum_x;
		dy = longint'(set_n) * longint'(pt_y[i]) - sum_y;
		return dx * dx + dy * dy;
	endfunction

	function automatic logic signed [CEN_W-1:0] centroid_of(input longint s);
		longint q;
		q = ((s < 0 ? -s : s) <<< FRAC_W) / set_n;
		if (s < 0) begin
			return CEN_W'((q > -CEN_LO) ? CEN_LO : -q);
		end
		return CEN_W'((q > CEN_HI) ? CEN_HI : q);
	endfunction

	function automatic set_summary_t summarize_set();
		set_summary_t s;
		longint       d;
		longint       near_d;
		longint       far_d;
		int           near_i;
		int           far_i;
		near_i = 0;
		far_i  = 0;
		near_d = scaled_dist(0);
		far_d  = near_d;
		for (int i = 1; i < set_n; i++) begin
			d = scaled_dist(i);
			// strict compares: earliest point keeps a tie
			if (d < near_d) begin
				near_d = d;
				near_i = i;
			end
			if (d > far_d) begin
				far_d = d;
				far_i = i;
			end
		end
		s.cx      = centroid_of(sum_x);
		s.cy      = centroid_of(sum_y);
		s.nx      = pt_x[near_i];
		s.ny      = pt_y[near_i];
		s.fx      = pt_x[far_i];
		s.fy      = pt_y[far_i];
		s.n       = set_n[PCNT_W-1:0];
		s.dropped = set_dropped;
		return s;
	endfunction

	function automatic void take_point(input coord_t x, input coord_t y, input logic last);
		if (set_n < MAX_PTS) begin
			pt_x[set_n] = x;
			pt_y[set_n] = y;
			sum_x += x;
			sum_y += y;
			set_n++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			expected_summaries.push_back(summarize_set());
			set_n       = 0;
			sum_x       = 0;
			sum_y       = 0;
			set_dropped = 1'b0;
		end
	endfunction

	task automatic send_point(input coord_t x, input coord_t y, input logic last);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		coord_x    <= x;
		coord_y    <= y;
		last_point <= last;
		do @(posedge clk); while (in_stall);
		take_point(x, y, last);
		points_sent++;
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		set_summary_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_summaries.size() == 0) begin
				mismatch_count++;
				$display("%0t: result transfer expected none, got count %0d centroid (%0d,%0d)",
					$time, point_count, centroid_x, centroid_y);
			end else begin
				e = expected_summaries.pop_front();
				check_field("centroid_x", e.cx, centroid_x);
				check_field("centroid_y", e.cy, centroid_y);
				check_field("nearest_x", e.nx, nearest_x);
				check_field("nearest_y", e.ny, nearest_y);
				check_field("farthest_x", e.fx, farthest_x);
				check_field("farthest_y", e.fy, farthest_y);
				check_field("point_count", e.n, point_count);
				check_field("overflow", e.dropped, overflow);
			end
		end
	end

	function automatic coord_t pick_coord(input spread_t spread, input coord_t center);
		coord_t edges [7] = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFE,
			16'sh7FFF};
		case (spread)
			SPREAD_TINY:    return coord_t'($urandom_range(0, 6)) - 16'sd3;
			SPREAD_EDGES:   return edges[$urandom_range(0, 6)];
			SPREAD_CLUSTER: return center + coord_t'($urandom_range(0, 64)) - 16'sd32;
			default:        return coord_t'($urandom);
		endcase
	endfunction

	task automatic test_single_points();
		send_point(16'sh8000, 16'sh8000, 1'b1);
		send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd1, -16'sd1, 1'b1);
	endtask

	// two points equally far from the centroid: first one is both answers
	task automatic test_tie_order();
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd2, 16'sd0, 1'b1);
	endtask

	// full store of identical extreme points, then a dropped closing point
	task automatic test_store_full();
		for (int i = 0; i < MAX_PTS; i++)
			send_point(16'sh8000, 16'sh7FFF, 1'b0);
		send_point(16'sh1234, -16'sh1234, 1'b1);
	endtask

	task automatic test_random_sets(input int n_points, input int s_pct, input int r_pct);
		int      target;
		int      size;
		int      r;
		spread_t spread;
		coord_t  cx;
		coord_t  cy;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		target = points_sent + n_points;
		while (points_sent < target) begin
			r = $urandom_range(99);
			if (r < 70)
				size = $urandom_range(1, 6);
			else if (r < 92)
				size = $urandom_range(7, MAX_PTS);
			else
				size = $urandom_range(MAX_PTS + 1, MAX_PTS + 4);
			spread = spread_t'($urandom_range(0, 3));
			cx = coord_t'($urandom);
			cy = coord_t'($urandom);
			for (int i = 0; i < size; i++)
				send_point(pick_coord(spread, cx), pick_coord(spread, cy), i == size - 1);
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		coord_x        = '0;
		coord_y        = '0;
		last_point     = 1'b0;
		out_stall      = 1'b0;
		set_n          = 0;
		sum_x          = 0;
		sum_y          = 0;
		set_dropped    = 1'b0;
		mismatch_count = 0;
		points_sent    = 0;
		send_idle_pct  = 35;
		recv_idle_pct  = 48;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_points();
		test_tie_order();
		test_store_full();
		test_random_sets(360, 35, 48);
		test_random_sets(360, 48, 35);
		test_random_sets(360, 0, 0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_summaries.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("centroid_nearest_farthest_point_unit_tb: done, clean");
		else
			$display("centroid_nearest_farthest_point_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, expected_summaries.size());
		$display("centroid_nearest_farthest_point_unit_tb: done, errors");
		$finish;
	end

endmodule
